FILE: design/cdi_pkg.sv
package cdi_pkg;

    // field widths
    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int WD_W    = 3;
    localparam int MASK_W  = 7;
    localparam int DOY_W   = 9;

    // shifted year (year + 400) and running weekday sum width
    localparam int Y_W   = 15;
    localparam int SUM_W = 15;

    // month codes
    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    // weekday codes
    localparam logic [WD_W-1:0] WD_SATURDAY = 3'd6;

    // year offset that keeps the weekday sum non-negative
    localparam logic [Y_W-1:0] YEAR_BIAS = 15'd400;

    // reciprocal of 100, exact for y below 2^15 with a shift of 21;
    // the same constant with a shift of 23 is exact for a divide by 400
    localparam logic [Y_W-1:0] RECIP_100 = 15'd20972;
    localparam int             SHIFT_100 = 21;
    localparam int             SHIFT_400 = 23;

    // odd-factor divisibility test by 25 through the modular inverse
    localparam logic [YEAR_W-1:0] INV_25       = 14'd7209;
    localparam logic [YEAR_W-1:0] DIV25_LIMIT  = 14'd655;

    // weekend mask after reset: friday and saturday
    localparam logic [MASK_W-1:0] MASK_RESET = 7'd96;

    // word passed from the decode stage to the finish stage
    typedef struct packed {
        logic [SUM_W-1:0]   partial;
        logic [7:0]         q100;
        logic [5:0]         q400;
        logic               leap;
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
    } mid_t;

    // days in each month of a common year
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month);
        logic [DAY_W-1:0] len;
        case (month)
            4'd1:    len = 5'd31;
            4'd2:    len = 5'd28;
            4'd3:    len = 5'd31;
            4'd4:    len = 5'd30;
            4'd5:    len = 5'd31;
            4'd6:    len = 5'd30;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd31;
            4'd9:    len = 5'd30;
            4'd10:   len = 5'd31;
            4'd11:   len = 5'd30;
            4'd12:   len = 5'd31;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

    // days in the common year before the first of each month
    function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] month);
        logic [DOY_W-1:0] cnt;
        case (month)
            4'd1:    cnt = 9'd0;
            4'd2:    cnt = 9'd31;
            4'd3:    cnt = 9'd59;
            4'd4:    cnt = 9'd90;
            4'd5:    cnt = 9'd120;
            4'd6:    cnt = 9'd151;
            4'd7:    cnt = 9'd181;
            4'd8:    cnt = 9'd212;
            4'd9:    cnt = 9'd243;
            4'd10:   cnt = 9'd273;
            4'd11:   cnt = 9'd304;
            4'd12:   cnt = 9'd334;
            default: cnt = 9'd0;
        endcase
        return cnt;
    endfunction

    // floor(31 * m / 12) where march is m = 1 and february is m = 12
    function automatic logic [DAY_W-1:0] month_term(input logic [MONTH_W-1:0] month);
        logic [DAY_W-1:0] term;
        case (month)
            4'd1:    term = 5'd28;
            4'd2:    term = 5'd31;
            4'd3:    term = 5'd2;
            4'd4:    term = 5'd5;
            4'd5:    term = 5'd7;
            4'd6:    term = 5'd10;
            4'd7:    term = 5'd12;
            4'd8:    term = 5'd15;
            4'd9:    term = 5'd18;
            4'd10:   term = 5'd20;
            4'd11:   term = 5'd23;
            4'd12:   term = 5'd25;
            default: term = 5'd0;
        endcase
        return term;
    endfunction

endpackage

FILE: design/calendar_date_info_core.sv
// calendar date info core
//
// a date word (day_in, month_in, year_in) is taken at a rising edge where
// start is high and busy is low; busy is always low, so one date can be
// started every cycle and the block runs at one word per clock.
// each date gives exactly one result word on the output ports, marked by
// done for a single cycle. the date passes through the input register,
// the decode register (constant multiply for the century quotients and
// the leap test) and the result register (mod 7, month tables).
// the receiver cannot stall; results are never held and must be taken in
// the cycle done is high.
// weekend_mask is written through weekend_mask_we / weekend_mask_wdata at
// an edge with the enable high; the user must write it only while no date
// is in flight, as the block itself does not enforce this.
// reset (rst_n low, asynchronous) clears the pipeline valids, so no done
// strobe follows, and sets the weekend mask to friday and saturday.
// an invalid date returns date_valid low and all other fields zero.
module calendar_date_info_core
    import cdi_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [DAY_W-1:0]   day_in,
    input  logic [MONTH_W-1:0] month_in,
    input  logic [YEAR_W-1:0]  year_in,
    input  logic               weekend_mask_we,
    input  logic [MASK_W-1:0]  weekend_mask_wdata,
    output logic               done,
    output logic [WD_W-1:0]    weekday,
    output logic               is_week_end_day,
    output logic               is_weekend,
    output logic               is_business_day,
    output logic [WD_W-1:0]    days_to_week_end,
    output logic [DAY_W-1:0]   days_to_month_end,
    output logic [DOY_W-1:0]   days_to_year_end,
    output logic               date_valid
);

    logic               accept;
    logic               in_valid_reg;
    logic [DAY_W-1:0]   day_reg;
    logic [MONTH_W-1:0] month_reg;
    logic [YEAR_W-1:0]  year_reg;
    logic [MASK_W-1:0]  weekend_mask_reg;
    logic               mid_valid;
    mid_t               mid;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // input valid and weekend mask
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            weekend_mask_reg <= MASK_RESET;
        end
        else
        begin
            in_valid_reg <= accept;
            if (weekend_mask_we)
            begin
                weekend_mask_reg <= weekend_mask_wdata;
            end
        end
    end

    // input word
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            day_reg   <= day_in;
            month_reg <= month_in;
            year_reg  <= year_in;
        end
    end

    cdi_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid_reg),
        .day       (day_reg),
        .month     (month_reg),
        .year      (year_reg),
        .mid_valid (mid_valid),
        .mid       (mid)
    );

    cdi_finish u_finish (
        .clk               (clk),
        .rst_n             (rst_n),
        .mid_valid         (mid_valid),
        .mid               (mid),
        .weekend_mask      (weekend_mask_reg),
        .done              (done),
        .weekday           (weekday),
        .is_week_end_day   (is_week_end_day),
        .is_weekend        (is_weekend),
        .is_business_day   (is_business_day),
        .days_to_week_end  (days_to_week_end),
        .days_to_month_end (days_to_month_end),
        .days_to_year_end  (days_to_year_end),
        .date_valid        (date_valid)
    );

`ifndef SYNTHESIS
    // every accepted date gives its result once the input register valid has passed the decode and result registers
    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done == $past(in_valid_reg, 2))
        else $error("result strobe does not follow accepted date");

    // invalid date returns a zero word
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !date_valid) |-> (weekday == '0 && days_to_year_end == '0 &&
        days_to_month_end == '0 && !is_business_day && !is_weekend))
        else $error("invalid date with nonzero fields");

    // valid date fields agree with each other
    a_valid_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (done && date_valid) |-> (days_to_week_end == WD_SATURDAY - weekday &&
        is_business_day != is_weekend && weekday <= WD_SATURDAY &&
        days_to_month_end != '0 && days_to_year_end != '0))
        else $error("inconsistent fields on valid date");

    // weekend flag follows the mask bit of the weekday
    a_mask_bit: assert property (@(posedge clk) disable iff (!rst_n)
        (done && date_valid) |-> (is_weekend == weekend_mask_reg[weekday]))
        else $error("weekend flag does not match mask");
`endif

endmodule

FILE: design/cdi_decode.sv
module cdi_decode
    import cdi_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [DAY_W-1:0]   day,
    input  logic [MONTH_W-1:0] month,
    input  logic [YEAR_W-1:0]  year,
    output logic               mid_valid,
    output mid_t               mid
);

    logic             jan_feb;
    logic [Y_W-1:0]   y_shift;
    logic [29:0]      recip_prod;
    logic [YEAR_W-1:0] mod25_prod;
    logic             div4;
    logic             div16;
    logic             div25;
    mid_t             mid_next;
    mid_t             mid_reg;
    logic             mid_valid_reg;

    // january and february count as months of the previous year
    assign jan_feb = (month == MONTH_JAN) || (month == MONTH_FEB);
    assign y_shift = Y_W'(year) + YEAR_BIAS - Y_W'(jan_feb);

    // one constant multiply gives both the century and 400-year quotients
    assign recip_prod = 30'(y_shift) * 30'(RECIP_100);

    // leap year test; divisible by 25 when year * inv(25) lands low
    assign mod25_prod = year * INV_25;
    assign div4       = (year[1:0] == 2'd0);
    assign div16      = (year[3:0] == 4'd0);
    assign div25      = (mod25_prod <= DIV25_LIMIT);

    always_comb
    begin
        mid_next.partial = SUM_W'(y_shift) + SUM_W'(y_shift[Y_W-1:2])
                         + SUM_W'(day) + SUM_W'(month_term(month));
        mid_next.q100    = recip_prod[SHIFT_100+7:SHIFT_100];
        mid_next.q400    = recip_prod[SHIFT_400+5:SHIFT_400];
        mid_next.leap    = div4 && (!div25 || div16);
        mid_next.day     = day;
        mid_next.month   = month;
    end

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_valid_reg <= 1'b0;
        end
        else
        begin
            mid_valid_reg <= in_valid;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        mid_reg <= mid_next;
    end

    assign mid_valid = mid_valid_reg;
    assign mid       = mid_reg;

endmodule

FILE: design/cdi_finish.sv
module cdi_finish
    import cdi_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               mid_valid,
    input  mid_t               mid,
    input  logic [MASK_W-1:0]  weekend_mask,
    output logic               done,
    output logic [WD_W-1:0]    weekday,
    output logic               is_week_end_day,
    output logic               is_weekend,
    output logic               is_business_day,
    output logic [WD_W-1:0]    days_to_week_end,
    output logic [DAY_W-1:0]   days_to_month_end,
    output logic [DOY_W-1:0]   days_to_year_end,
    output logic               date_valid
);

    logic [SUM_W-1:0]  wd_sum;
    logic [5:0]        fold1;
    logic [3:0]        fold2;
    logic [WD_W-1:0]   wd;
    logic [DAY_W-1:0]  mlen;
    logic              month_ok;
    logic              valid;
    logic              wkend;
    logic [DOY_W-1:0]  doy;
    logic [DOY_W-1:0]  ylen;

    logic              done_reg;
    logic [WD_W-1:0]   weekday_reg,          weekday_next;
    logic              is_week_end_day_reg,  is_week_end_day_next;
    logic              is_weekend_reg,       is_weekend_next;
    logic              is_business_day_reg,  is_business_day_next;
    logic [WD_W-1:0]   days_to_week_end_reg, days_to_week_end_next;
    logic [DAY_W-1:0]  days_to_month_end_reg, days_to_month_end_next;
    logic [DOY_W-1:0]  days_to_year_end_reg, days_to_year_end_next;
    logic              date_valid_reg,       date_valid_next;

    // weekday sum, always positive thanks to the year bias
    assign wd_sum = mid.partial - SUM_W'(mid.q100) + SUM_W'(mid.q400);

    // mod 7 by folding octal digits, since 8 is 1 mod 7
    assign fold1 = 6'(wd_sum[2:0]) + 6'(wd_sum[5:3]) + 6'(wd_sum[8:6])
                 + 6'(wd_sum[11:9]) + 6'(wd_sum[14:12]);
    assign fold2 = 4'(fold1[2:0]) + 4'(fold1[5:3]);
    assign wd    = (fold2 >= 4'd7) ? 3'(fold2 - 4'd7) : fold2[2:0];

    // month length and date check
    always_comb
    begin
        mlen = month_len(mid.month);
        if ((mid.month == MONTH_FEB) && mid.leap)
        begin
            mlen = 5'd29;
        end
    end

    assign month_ok = mid.month inside {[MONTH_JAN:MONTH_DEC]};
    assign valid    = month_ok && (mid.day != 5'd0) && (mid.day <= mlen);

    // day of year and year length
    assign doy  = days_before(mid.month) + DOY_W'(mid.day)
                + DOY_W'((mid.month > MONTH_FEB) && mid.leap);
    assign ylen = mid.leap ? 9'd366 : 9'd365;

    assign wkend = weekend_mask[wd];

    // result word, all zero for an invalid date
    always_comb
    begin
        weekday_next           = '0;
        is_week_end_day_next   = 1'b0;
        is_weekend_next        = 1'b0;
        is_business_day_next   = 1'b0;
        days_to_week_end_next  = '0;
        days_to_month_end_next = '0;
        days_to_year_end_next  = '0;
        date_valid_next        = 1'b0;
        if (valid)
        begin
            weekday_next           = wd;
            is_week_end_day_next   = (wd == WD_SATURDAY);
            is_weekend_next        = wkend;
            is_business_day_next   = !wkend;
            days_to_week_end_next  = WD_SATURDAY - wd;
            days_to_month_end_next = mlen - mid.day + 5'd1;
            days_to_year_end_next  = ylen - doy + 9'd1;
            date_valid_next        = 1'b1;
        end
    end

    // result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= mid_valid;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        weekday_reg           <= weekday_next;
        is_week_end_day_reg   <= is_week_end_day_next;
        is_weekend_reg        <= is_weekend_next;
        is_business_day_reg   <= is_business_day_next;
        days_to_week_end_reg  <= days_to_week_end_next;
        days_to_month_end_reg <= days_to_month_end_next;
        days_to_year_end_reg  <= days_to_year_end_next;
        date_valid_reg        <= date_valid_next;
    end

    assign done              = done_reg;
    assign weekday           = weekday_reg;
    assign is_week_end_day   = is_week_end_day_reg;
    assign is_weekend        = is_weekend_reg;
    assign is_business_day   = is_business_day_reg;
    assign days_to_week_end  = days_to_week_end_reg;
    assign days_to_month_end = days_to_month_end_reg;
    assign days_to_year_end  = days_to_year_end_reg;
    assign date_valid        = date_valid_reg;

endmodule

FILE: tb/tb_calendar_date_info_core.sv
`timescale 1ns / 1ps

module tb_calendar_date_info_core;

    import cdi_pkg::*;

    // one date word as driven into the block
    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } date_word_t;

    // calendar facts predicted for one date
    typedef struct packed {
        logic [WD_W-1:0]  weekday;
        logic             week_end_day;
        logic             weekend;
        logic             business;
        logic [WD_W-1:0]  to_week_end;
        logic [DAY_W-1:0] to_month_end;
        logic [DOY_W-1:0] to_year_end;
        logic             valid;
    } date_facts_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [DAY_W-1:0]    day_in = '0;
    logic [MONTH_W-1:0]  month_in = '0;
    logic [YEAR_W-1:0]   year_in = '0;
    logic                weekend_mask_we = 1'b0;
    logic [MASK_W-1:0]   weekend_mask_wdata = '0;
    logic                done;
    logic [WD_W-1:0]     weekday;
    logic                is_week_end_day;
    logic                is_weekend;
    logic                is_business_day;
    logic [WD_W-1:0]     days_to_week_end;
    logic [DAY_W-1:0]    days_to_month_end;
    logic [DOY_W-1:0]    days_to_year_end;
    logic                date_valid;

    date_word_t          pending_dates[$];
    date_facts_t         expected_facts[$];
    logic [MASK_W-1:0]   weekend_mask_now = MASK_RESET;
    int unsigned         common_days[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    int                  err_count = 0;
    int                  results_seen = 0;
    int                  valid_seen = 0;
    int                  masks_used = 1;
    int                  gap_left = 0;
    int                  calm_left = 0;

    calendar_date_info_core dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .start              (start),
        .busy               (busy),
        .day_in             (day_in),
        .month_in           (month_in),
        .year_in            (year_in),
        .weekend_mask_we    (weekend_mask_we),
        .weekend_mask_wdata (weekend_mask_wdata),
        .done               (done),
        .weekday            (weekday),
        .is_week_end_day    (is_week_end_day),
        .is_weekend         (is_weekend),
        .is_business_day    (is_business_day),
        .days_to_week_end   (days_to_week_end),
        .days_to_month_end  (days_to_month_end),
        .days_to_year_end   (days_to_year_end),
        .date_valid         (date_valid)
    );

    // clock
    always #10 clk = ~clk;

    // gregorian leap rule
    function automatic bit is_leap(input int unsigned yr);
        return ((yr % 4) == 0 && (yr % 100) != 0) || (yr % 400) == 0;
    endfunction

    // month length, month must be 1..12
    function automatic int unsigned month_days(input int unsigned mo, input int unsigned yr);
        if (mo == MONTH_FEB && is_leap(yr))
            return 29;
        return common_days[mo - 1];
    endfunction

    // expected facts for one date under the given weekend mask
    function automatic date_facts_t calc_date_facts(input date_word_t w,
                                                    input logic [MASK_W-1:0] mask);
        date_facts_t f;
        int unsigned d, mo, yr, len, a, y, mm, wd, doy;
        f = '0;
        d = w.day;
        mo = w.month;
        yr = w.year;
        if (w.month < MONTH_JAN || w.month > MONTH_DEC)
            return f;
        len = month_days(mo, yr);
        if (d < 1 || d > len)
            return f;
        // zeller style congruence with the year shifted by 400
        a = (14 - mo) / 12;
        y = yr + 400 - a;
        mm = mo + 12 * a - 2;
        wd = (d + y + y / 4 - y / 100 + y / 400 + (31 * mm) / 12) % 7;
        // day of year counting this day
        doy = d;
        for (int i = 1; i < mo; i++)
            doy += month_days(i, yr);
        f.weekday = WD_W'(wd);
        f.week_end_day = (f.weekday == WD_SATURDAY);
        f.weekend = mask[wd];
        f.business = ~mask[wd];
        f.to_week_end = WD_W'(6 - wd);
        f.to_month_end = DAY_W'(len - d + 1);
        f.to_year_end = DOY_W'((is_leap(yr) ? 366 : 365) - doy + 1);
        f.valid = 1'b1;
        return f;
    endfunction

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (act_v !== exp_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            err_count++;
        end
    endtask

    task automatic add_date(input int unsigned d, input int unsigned mo, input int unsigned yr);
        date_word_t w;
        w.day = DAY_W'(d);
        w.month = MONTH_W'(mo);
        w.year = YEAR_W'(yr);
        pending_dates.push_back(w);
    endtask

    // mostly well-formed dates, some with leap-relevant years, rest raw noise
    task automatic queue_random_dates(input int count);
        date_word_t w;
        int unsigned r, yr, mo, len;
        repeat (count)
        begin
            r = $urandom_range(0, 99);
            if (r < 15)
            begin
                w.day = DAY_W'($urandom);
                w.month = MONTH_W'($urandom);
                w.year = YEAR_W'($urandom);
            end
            else
            begin
                mo = $urandom_range(1, 12);
                r = $urandom_range(0, 9);
                if (r < 5)
                    yr = $urandom_range(1, 9999);
                else if (r < 7)
                    yr = $urandom_range(0, 2499) * 4;
                else if (r < 8)
                    yr = $urandom_range(0, 99) * 100;
                else if (r < 9)
                    yr = $urandom_range(0, 40) * 400;
                else
                    yr = $urandom_range(0, 16383);
                len = month_days(mo, yr);
                // lean on the last days of the month
                if ($urandom_range(0, 9) < 3)
                    w.day = DAY_W'($urandom_range(len - 2, len));
                else
                    w.day = DAY_W'($urandom_range(1, len));
                w.month = MONTH_W'(mo);
                w.year = YEAR_W'(yr);
            end
            pending_dates.push_back(w);
        end
    endtask

    // all words sent and all results back
    task automatic wait_idle();
        while (pending_dates.size() != 0 || start || expected_facts.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_weekend_mask(input logic [MASK_W-1:0] value);
        @(posedge clk);
        weekend_mask_we <= 1'b1;
        weekend_mask_wdata <= value;
        @(posedge clk);
        weekend_mask_we <= 1'b0;
        weekend_mask_now = value;
        masks_used++;
    endtask

    // driver: predicts on accept, then loads the next word after a random gap
    always @(posedge clk)
    begin : date_driver
        date_word_t w;
        logic nxt_start;
        int unsigned r;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            nxt_start = start;
            if (start && !busy)
            begin
                w.day = day_in;
                w.month = month_in;
                w.year = year_in;
                expected_facts.push_back(calc_date_facts(w, weekend_mask_now));
                nxt_start = 1'b0;
                // gap before next word: mostly none or short, a few long
                r = $urandom_range(0, 99);
                if (calm_left > 0)
                begin
                    calm_left--;
                    gap_left = 0;
                end
                else if (r < 3)
                begin
                    calm_left = $urandom_range(20, 80);
                    gap_left = 0;
                end
                else if (r < 50)
                    gap_left = 0;
                else if (r < 85)
                    gap_left = $urandom_range(1, 3);
                else if (r < 97)
                    gap_left = $urandom_range(4, 12);
                else
                    gap_left = $urandom_range(20, 60);
            end
            if (!nxt_start)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_dates.size() != 0)
                begin
                    w = pending_dates.pop_front();
                    day_in <= w.day;
                    month_in <= w.month;
                    year_in <= w.year;
                    nxt_start = 1'b1;
                end
            end
            start <= nxt_start;
        end
    end

    // monitor: compare each result word with the oldest prediction
    always @(posedge clk)
    begin : result_monitor
        date_facts_t e;
        if (rst_n && done)
        begin
            if (expected_facts.size() == 0)
            begin
                $error("result word with no date outstanding");
                err_count++;
            end
            else
            begin
                e = expected_facts.pop_front();
                results_seen++;
                if (e.valid)
                    valid_seen++;
                check_field("weekday", e.weekday, weekday);
                check_field("is_week_end_day", e.week_end_day, is_week_end_day);
                check_field("is_weekend", e.weekend, is_weekend);
                check_field("is_business_day", e.business, is_business_day);
                check_field("days_to_week_end", e.to_week_end, days_to_week_end);
                check_field("days_to_month_end", e.to_month_end, days_to_month_end);
                check_field("days_to_year_end", e.to_year_end, days_to_year_end);
                check_field("date_valid", e.valid, date_valid);
            end
        end
    end

    // main sequence
    initial
    begin
        logic [MASK_W-1:0] masks[6];
        masks[0] = 7'd0;
        masks[1] = 7'd127;
        masks[2] = 7'h41;
        masks[3] = MASK_W'($urandom_range(0, 127));
        masks[4] = MASK_W'($urandom_range(0, 127));
        masks[5] = MASK_W'($urandom_range(0, 127));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed dates under the reset mask
        add_date(1, 1, 1);          // first day of year one
        add_date(31, 12, 9999);     // last day of last year
        add_date(1, 1, 2000);       // full leap year ahead
        add_date(29, 2, 2000);      // leap by the 400 rule
        add_date(29, 2, 1900);      // century, not leap
        add_date(28, 2, 1900);
        add_date(29, 2, 2024);
        add_date(29, 2, 2023);      // leap day in common year
        add_date(1, 3, 2024);
        add_date(31, 12, 2024);
        add_date(0, 5, 2021);       // day zero
        add_date(31, 4, 2021);      // past month end
        add_date(30, 4, 2021);
        add_date(15, 0, 2021);      // month zero
        add_date(15, 13, 2021);     // month past december
        add_date(31, 15, 16383);    // all ones
        add_date(0, 0, 0);          // all zeros
        add_date(29, 2, 0);         // year zero is leap
        add_date(31, 12, 16383);    // beyond 9999
        add_date(1, 1, 10000);
        add_date(15, 6, 1970);
        add_date(31, 1, 2021);
        add_date(31, 3, 2021);
        queue_random_dates(260);

        // remaining phases, each with its own weekend mask
        for (int p = 0; p < 6; p++)
        begin
            wait_idle();
            write_weekend_mask(masks[p]);
            queue_random_dates(240);
        end
        wait_idle();
        repeat (6) @(posedge clk);

        if (expected_facts.size() != 0)
        begin
            $error("%0d dates never produced a result", expected_facts.size());
            err_count++;
        end
        $display("checked %0d result words (%0d valid dates, %0d invalid)",
                 results_seen, valid_seen, results_seen - valid_seen);
        $display("weekend mask settings exercised: %0d", masks_used);
        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // watchdog
    initial
    begin
        #10_000_000;
        $display("timeout waiting for the block");
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: files.f
design/cdi_pkg.sv
design/cdi_decode.sv
design/cdi_finish.sv
design/calendar_date_info_core.sv
tb/tb_calendar_date_info_core.sv
